// File: src/sspm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspm_pkg: shared types and constants of the string pattern matcher
// Configuration layout, queue entry format, register indexes, mode codes
// and the ASCII case folding helper.
// ----------------------------------------------------------------------------
package sspm_pkg;

    localparam int PATTERN_WORDS = 4;
    localparam int WORD_W        = 64;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 6;
    localparam int MODE_W        = 2;
    localparam int INDEX_W       = 3;

    // Register indexes of the configuration port
    localparam logic [INDEX_W-1:0] REG_PATTERN_0   = 3'd0;
    localparam logic [INDEX_W-1:0] REG_PATTERN_1   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_PATTERN_2   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_PATTERN_3   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_LENGTH      = 3'd4;
    localparam logic [INDEX_W-1:0] REG_MODE        = 3'd5;
    localparam logic [INDEX_W-1:0] REG_IGNORE_CASE = 3'd6;

    // Match modes
    localparam logic [MODE_W-1:0] MODE_EXACT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PREFIX   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUFFIX   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd3;

    // Subject byte counter saturates here
    localparam logic [LEN_W-1:0] COUNT_MAX = 6'd63;

    // Entries in the queue between front and back; a power of two
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [PATTERN_WORDS-1:0][WORD_W-1:0] pattern;
        logic [LEN_W-1:0]                     length;
        logic [MODE_W-1:0]                    mode;
        logic                                 ignore_case;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;   // already folded
        logic              valid;
        logic              last;
    } item_t;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                    input logic ic);
        logic [BYTE_W-1:0] r;
        if (ic && c >= 8'h61 && c <= 8'h7A)
            r = c - 8'h20;
        else
            r = c;
        return r;
    endfunction

    // Pattern byte k, folded under the current case setting
    function automatic logic [BYTE_W-1:0] pattern_byte(input cfg_t cfg,
                                                       input logic [4:0] k);
        logic [BYTE_W-1:0] raw;
        raw = cfg.pattern[k[4:3]][{k[2:0], 3'b000} +: BYTE_W];
        return fold_byte(raw, cfg.ignore_case);
    endfunction

endpackage
`default_nettype wire

// File: src/sspm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspm_front: input side of the matcher
// Accept subject transfers, fold the byte and drop idle items before they
// reach the queue.
// ----------------------------------------------------------------------------
module sspm_front
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] subject_byte
    input  wire logic                 s_tuser,   // byte_valid
    input  wire logic                 s_tlast,   // end_of_subject
    input  wire sspm_pkg::cfg_t       cfg,
    input  wire logic                 q_full,
    output logic                      q_push,
    output sspm_pkg::item_t           q_item
);

    assign s_tready = !q_full;

    // Items that are neither a byte nor an end marker change nothing: drop
    assign q_push = s_tvalid && s_tready && (s_tuser || s_tlast);

    always_comb
    begin
        q_item.data  = sspm_pkg::fold_byte(s_tdata, cfg.ignore_case);
        q_item.valid = s_tuser;
        q_item.last  = s_tlast;
    end

endmodule
`default_nettype wire

// File: src/sspm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspm_queue: short item queue
// Decouple the front from the match engine so that each side stalls alone.
// ----------------------------------------------------------------------------
module sspm_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sspm_pkg::item_t push_item,
    input  wire logic            pop,
    output logic                 full,
    output logic                 head_valid,
    output sspm_pkg::item_t      head_item
);

    localparam int PTR_W   = $clog2(sspm_pkg::QUEUE_DEPTH);
    localparam int LEVEL_W = $clog2(sspm_pkg::QUEUE_DEPTH + 1);
    localparam logic [LEVEL_W-1:0] DEPTH_L = LEVEL_W'(sspm_pkg::QUEUE_DEPTH);

    sspm_pkg::item_t    entry_reg [sspm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;

    assign full       = (level_reg == DEPTH_L);
    assign head_valid = (level_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
            level_next = level_reg + 1'b1;
        else if (pop && !push)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

// File: src/sspm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspm_back: match engine
// Shift the window, track prefix and containment, and register the result
// of each subject for the output channel.
// ----------------------------------------------------------------------------
module sspm_back
#(
    parameter int MAX_PATTERN = 32
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sspm_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    input  wire sspm_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata
);

    localparam int LW = sspm_pkg::LEN_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

    logic [7:0]             win_reg   [MAX_PATTERN];
    logic [7:0]             win_eff   [MAX_PATTERN];
    logic [7:0]             apat_reg  [MAX_PATTERN];
    logic [7:0]             apat_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] amask_reg;
    logic [MAX_PATTERN-1:0] amask_next;
    logic [MAX_PATTERN-1:0] eq;
    logic [LW-1:0]          count_reg;
    logic [LW-1:0]          count_eff;
    logic                   prefix_reg;
    logic                   prefix_eff;
    logic                   found_reg;
    logic                   found_eff;
    logic [LW-1:0]          len_eff;
    logic                   tail_hit;
    logic                   shift;
    logic                   out_free;
    logic                   match_bit;
    logic                   out_valid_reg;
    logic                   out_match_reg;

    assign len_eff = (cfg.length > MAX_LEN) ? MAX_LEN : cfg.length;

    // Pattern aligned to the window: entry j holds pattern byte len-1-j
    always_comb
    begin
        logic [LW-1:0] idx;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            idx           = len_eff - LW'(j) - 1'b1;
            apat_next[j]  = sspm_pkg::pattern_byte(cfg, idx[4:0]);
            amask_next[j] = (LW'(j) < len_eff);
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = q_valid && (!q_item.last || out_free);
    assign shift    = q_item.valid;

    always_comb
    begin
        win_eff[0] = shift ? q_item.data : win_reg[0];
        for (int j = 1; j < MAX_PATTERN; j++)
            win_eff[j] = shift ? win_reg[j-1] : win_reg[j];
    end

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
            eq[j] = (win_eff[j] == apat_reg[j]) || !amask_reg[j];
    end

    always_comb
    begin
        if (shift && count_reg != sspm_pkg::COUNT_MAX)
            count_eff = count_reg + 1'b1;
        else
            count_eff = count_reg;

        prefix_eff = prefix_reg;
        if (shift && count_reg < len_eff &&
            q_item.data != sspm_pkg::pattern_byte(cfg, count_reg[4:0]))
            prefix_eff = 1'b0;

        tail_hit  = (&eq) && (count_eff >= len_eff);
        found_eff = found_reg || (shift && len_eff != '0 && tail_hit);
    end

    always_comb
    begin
        unique case (cfg.mode)
            sspm_pkg::MODE_EXACT:    match_bit = (count_eff == len_eff) && prefix_eff;
            sspm_pkg::MODE_PREFIX:   match_bit = (count_eff >= len_eff) && prefix_eff;
            sspm_pkg::MODE_SUFFIX:   match_bit = tail_hit;
            sspm_pkg::MODE_CONTAINS: match_bit = (len_eff == '0) || found_eff;
            default:                 match_bit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prefix_reg    <= 1'b1;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (q_item.last)
                begin
                    count_reg  <= '0;
                    prefix_reg <= 1'b1;
                    found_reg  <= 1'b0;
                end
                else
                begin
                    count_reg  <= count_eff;
                    prefix_reg <= prefix_eff;
                    found_reg  <= found_eff;
                end
            end
            if (q_pop && q_item.last)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
            apat_reg[j] <= apat_next[j];
        amask_reg <= amask_next;
        if (q_pop && shift)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
                win_reg[j] <= win_eff[j];
        end
        if (q_pop && q_item.last)
            out_match_reg <= match_bit;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_match_reg};

endmodule
`default_nettype wire

// File: src/streaming_string_pattern_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// streaming_string_pattern_match: streaming subject/pattern matcher
// Match each streamed subject string against a configured pattern in exact,
// prefix, suffix or contains mode, with optional ASCII case folding.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one subject byte per transfer. tuser marks a real byte,
//   tlast marks the final item of a subject; an end item may carry no byte.
//   Items with neither flag are dropped at the front.
//   Master channel m_*: one transfer per subject, m_tdata[0] set on a match.
//   Configuration: cfg_wr_en, cfg_index and cfg_data write one register per
//   cycle; write only while no subject is in flight.
//   Result path: an end item is written into the queue, and the engine
//   registers its result in the output register when it pops that item.
//   Throughput: one item per cycle while no end item waits on a full output
//   register, set by the match engine, which compares the whole window with
//   the pattern in parallel on every byte.
//   Stalls: a four-entry queue between front and engine keeps the slave side
//   accepting while a result waits, until the queue fills; the engine halts
//   only on an end item that finds the output register full.
//   Reset: configuration returns to zero, the queue empties and the subject
//   state clears; the block accepts items from the first cycle after reset.
// ----------------------------------------------------------------------------
module streaming_string_pattern_match
#(
    parameter int MAX_PATTERN = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] subject_byte
    input  wire logic        s_tuser,    // byte_valid
    input  wire logic        s_tlast,    // end_of_subject
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [0] matched, [7:1] zero
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    sspm_pkg::cfg_t  cfg_reg;
    sspm_pkg::item_t push_item;
    sspm_pkg::item_t head_item;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_valid;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sspm_pkg::REG_PATTERN_0:   cfg_reg.pattern[0]  <= cfg_data;
                sspm_pkg::REG_PATTERN_1:   cfg_reg.pattern[1]  <= cfg_data;
                sspm_pkg::REG_PATTERN_2:   cfg_reg.pattern[2]  <= cfg_data;
                sspm_pkg::REG_PATTERN_3:   cfg_reg.pattern[3]  <= cfg_data;
                sspm_pkg::REG_LENGTH:      cfg_reg.length      <= cfg_data[5:0];
                sspm_pkg::REG_MODE:        cfg_reg.mode        <= cfg_data[1:0];
                sspm_pkg::REG_IGNORE_CASE: cfg_reg.ignore_case <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Front: accept, fold and filter transfers
    sspm_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // Queue: hold items between the two sides
    sspm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    // Back: window compare and result register
    sspm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // An end item never leaves the queue while a result still waits
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && head_item.last) |-> (!m_tvalid || m_tready))
        else $error("end item popped while output register occupied");

    // The engine never pops an empty queue
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // Idle transfers are dropped and never queued
    a_idle_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser && !s_tlast) |-> !q_push)
        else $error("idle transfer entered the queue");

    // A result appears only after an end item has been popped
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(q_pop && head_item.last))
        else $error("result without end item");

endmodule
`default_nettype wire

// File: tb/sv/sspm_match_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspm_match_check: result prediction and checking for the pattern matcher
// Watch the configuration port and both stream channels, keep a private copy
// of the registers and the subject state, predict the match flag of every
// subject and compare it with each result transfer in order.
// ----------------------------------------------------------------------------
module sspm_match_check
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               results_seen,
    output int               matches_seen
);

    // Register copy
    logic [63:0] pat_word [4];
    logic [5:0]  pat_len;
    logic [1:0]  mode_sel;
    logic        fold_on;

    // Subject state: window holds folded bytes, entry 0 the newest
    logic [7:0]  window [32];
    logic [5:0]  seen_count;
    logic        lead_ok;
    logic        found;

    logic        match_expected [$];
    logic        want;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (fold_on && c >= 8'h61 && c <= 8'h7A)
            return c - 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] pat_char(input int k);
        return upcase(pat_word[k / 8][(k % 8) * 8 +: 8]);
    endfunction

    function automatic int used_len();
        return (pat_len > 6'd32) ? 32 : int'(pat_len);
    endfunction

    function automatic logic tail_matches(input int len);
        int i;
        if (int'(seen_count) < len)
            return 1'b0;
        for (i = 0; i < len; i++)
            if (window[len - 1 - i] != pat_char(i))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_subject();
        int i;
        for (i = 0; i < 32; i++)
            window[i] = 8'h00;
        seen_count = '0;
        lead_ok    = 1'b1;
        found      = 1'b0;
    endtask

    // Advance the subject state by one accepted item; queue a flag on an end
    task automatic predict_item(input logic [7:0] c, input logic v, input logic l);
        int         len;
        int         i;
        logic [7:0] f;
        logic       m;
        len = used_len();
        if (v)
        begin
            f = upcase(c);
            if (int'(seen_count) < len && f != pat_char(int'(seen_count)))
                lead_ok = 1'b0;
            for (i = 31; i > 0; i--)
                window[i] = window[i - 1];
            window[0] = f;
            if (seen_count < sspm_pkg::COUNT_MAX)
                seen_count = seen_count + 6'd1;
            if (len > 0 && tail_matches(len))
                found = 1'b1;
        end
        if (l)
        begin
            case (mode_sel)
                sspm_pkg::MODE_EXACT:  m = (int'(seen_count) == len) && lead_ok;
                sspm_pkg::MODE_PREFIX: m = (int'(seen_count) >= len) && lead_ok;
                sspm_pkg::MODE_SUFFIX: m = tail_matches(len);
                default:               m = (len == 0) || found;
            endcase
            match_expected.push_back(m);
            clear_subject();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < 4; w++)
                pat_word[w] = '0;
            pat_len      = '0;
            mode_sel     = sspm_pkg::MODE_EXACT;
            fold_on      = 1'b0;
            clear_subject();
            match_expected.delete();
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
            matches_seen = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index) inside
                    sspm_pkg::REG_PATTERN_0, sspm_pkg::REG_PATTERN_1,
                    sspm_pkg::REG_PATTERN_2, sspm_pkg::REG_PATTERN_3:
                        pat_word[cfg_index[1:0]] = cfg_data;
                    sspm_pkg::REG_LENGTH:      pat_len  = cfg_data[5:0];
                    sspm_pkg::REG_MODE:        mode_sel = cfg_data[1:0];
                    sspm_pkg::REG_IGNORE_CASE: fold_on  = cfg_data[0];
                    default: ;
                endcase
            end
            // Check the result transfer before taking in this edge's item
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (match_expected.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with none waiting, expected none, actual %0d",
                             $time, m_tdata[0]);
                end
                else
                begin
                    want = match_expected.pop_front();
                    if (m_tdata[0] !== want)
                    begin
                        fail_count++;
                        $display("%0t: matched mismatch, expected %0d, actual %0d",
                                 $time, want, m_tdata[0]);
                    end
                end
                if (m_tdata[0] === 1'b1)
                    matches_seen++;
            end
            if (s_tvalid && s_tready)
                predict_item(s_tdata, s_tuser, s_tlast);
            pending = match_expected.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the streaming string pattern matcher
// Drive directed subjects, then phases of random subjects built around the
// configured pattern under changing register settings, with random idling
// on both channels, a long receiver hold-off and full drains between phases.
// ----------------------------------------------------------------------------
module tb;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] subject_byte
    logic        s_tuser   = 1'b0;    // byte_valid
    logic        s_tlast   = 1'b0;    // end_of_subject
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;             // [0] matched, [7:1] zero
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int results_seen;
    int matches_seen;

    // Stimulus state
    bit         idle_en;
    bit         noise_en;
    int         hold_cycles;
    int         items_sent;
    int         subjects_sent;
    int         settings_used;
    int         alpha_style;
    logic [7:0] pat_bytes [32];
    int         pat_len_cfg;
    logic [1:0] mode_cfg;
    logic       ic_cfg;
    logic [7:0] subj [$];

    streaming_string_pattern_match #(.MAX_PATTERN(32)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sspm_match_check match_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .matches_seen (matches_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: a long hold-off when asked, random stall bursts while idling
    // is on, otherwise always ready. One assignment per clock edge.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (!idle_en)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 11);
            end
        end
    end

    // Hold the write port for one edge per register; the caller lowers it
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write every register from the current pattern and settings
    task automatic load_settings();
        logic [63:0] word;
        logic [63:0] junk;
        int          w;
        int          b;
        for (w = 0; w < 4; w++)
        begin
            for (b = 0; b < 8; b++)
                word[b * 8 +: 8] = pat_bytes[w * 8 + b];
            case (w)
                0: reg_write(sspm_pkg::REG_PATTERN_0, word);
                1: reg_write(sspm_pkg::REG_PATTERN_1, word);
                2: reg_write(sspm_pkg::REG_PATTERN_2, word);
                default: reg_write(sspm_pkg::REG_PATTERN_3, word);
            endcase
        end
        // Unused upper bits of the narrow registers carry noise at times
        junk = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : 64'd0;
        reg_write(sspm_pkg::REG_LENGTH, {junk[63:6], 6'(pat_len_cfg)});
        reg_write(sspm_pkg::REG_MODE, {junk[63:2], mode_cfg});
        reg_write(sspm_pkg::REG_IGNORE_CASE, {junk[63:1], ic_cfg});
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Offer one item and hold it until the transfer; maybe idle afterwards
    task automatic push_item(input logic [7:0] b, input logic v, input logic l);
        s_tdata  <= b;
        s_tuser  <= v;
        s_tlast  <= l;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (v || l)
            items_sent++;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every outstanding result, then let the
    // pipeline settle before any register write
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        if (alpha_style != 0)
            return 8'($urandom_range(0, 255));
        r = $urandom_range(0, 17);
        case (r)
            12: return 8'h7A;
            13: return 8'h5A;
            14: return 8'h60;   // just below 'a'
            15: return 8'h7B;   // just above 'z'
            16: return 8'h40;
            17: return 8'h5B;
            default:
                case (r % 4)
                    0: return 8'h61;
                    1: return 8'h41;
                    2: return 8'h62;
                    default: return 8'h42;
                endcase
        endcase
    endfunction

    // Swap the case of a letter when folding is on, half of the time
    function automatic logic [7:0] vary(input logic [7:0] c);
        if (!ic_cfg || $urandom_range(0, 1) == 0)
            return c;
        if (c >= 8'h61 && c <= 8'h7A)
            return c - 8'h20;
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'h20;
        return c;
    endfunction

    function automatic int eff_len();
        return (pat_len_cfg > 32) ? 32 : pat_len_cfg;
    endfunction

    task automatic add_random(input int n);
        repeat (n) subj.push_back(pick_char());
    endtask

    task automatic add_pattern();
        int i;
        for (i = 0; i < eff_len(); i++)
            subj.push_back(vary(pat_bytes[i]));
    endtask

    // Build a subject: mostly shaped around the pattern, some pure noise
    task automatic build_subject();
        int kind;
        int idx;
        kind = $urandom_range(0, 19);
        subj.delete();
        case (kind) inside
            [0:3]:        add_pattern();
            [4:6]:
            begin
                add_pattern();
                add_random($urandom_range(1, 6));
            end
            [7:9]:
            begin
                add_random($urandom_range(1, 8));
                add_pattern();
            end
            [10:12]:
            begin
                add_random($urandom_range(1, 40));
                add_pattern();
                add_random($urandom_range(0, 5));
            end
            [13:14]:      add_random($urandom_range(0, 10));
            [15:16]:
            begin
                add_pattern();
                if (subj.size() > 0)
                begin
                    idx = $urandom_range(0, subj.size() - 1);
                    subj[idx] = pick_char();
                end
            end
            17:
            begin
                add_pattern();
                if (subj.size() > 0)
                    void'(subj.pop_back());
            end
            18:
            begin
                // Usually long enough to saturate the byte counter
                add_random($urandom_range(60, 70));
                add_pattern();
            end
            default: ;
        endcase
    endtask

    // Send the built subject; the end flag rides on the last byte or on a
    // separate empty end item, with idle items mixed in as noise
    task automatic send_subject();
        bit sep_end;
        int i;
        sep_end = (subj.size() == 0) || ($urandom_range(0, 5) == 0);
        for (i = 0; i < subj.size(); i++)
        begin
            if (noise_en && $urandom_range(0, 9) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(subj[i], 1'b1, !sep_end && (i == subj.size() - 1));
        end
        if (sep_end)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        subjects_sent++;
    endtask

    // Pick settings for one random phase; the early phases walk the extremes
    task automatic choose_settings(input int ph);
        int r;
        int i;
        alpha_style = ($urandom_range(0, 3) == 0) ? 1 : 0;
        r = $urandom_range(0, 9);
        if (r <= 5)
            pat_len_cfg = $urandom_range(1, 8);
        else if (r == 6)
            pat_len_cfg = 0;
        else if (r == 7)
            pat_len_cfg = $urandom_range(9, 32);
        else if (r == 8)
            pat_len_cfg = 32;
        else
            pat_len_cfg = $urandom_range(33, 63);
        for (i = 0; i < 32; i++)
            pat_bytes[i] = pick_char();
        mode_cfg = 2'($urandom_range(0, 3));
        ic_cfg   = 1'($urandom_range(0, 1));
        if (ph < 8)
        begin
            mode_cfg = 2'(ph);
            ic_cfg   = ph[2];
        end
        case (ph)
            0:
            begin
                // Full-length pattern of all ones
                alpha_style = 1;
                pat_len_cfg = 32;
                for (i = 0; i < 32; i++)
                    pat_bytes[i] = 8'hFF;
            end
            1:
            begin
                pat_len_cfg = 0;
                for (i = 0; i < 32; i++)
                    pat_bytes[i] = 8'h00;
            end
            2:       pat_len_cfg = 63;
            3:       pat_len_cfg = 1;
            default: ;
        endcase
    endtask

    initial
    begin
        int ph;
        int phase_start;
        int i;

        idle_en       = 1'b1;
        noise_en      = 1'b1;
        hold_cycles   = 0;
        items_sent    = 0;
        subjects_sent = 0;
        settings_used = 0;
        alpha_style   = 0;
        pat_len_cfg   = 0;
        mode_cfg      = sspm_pkg::MODE_EXACT;
        ic_cfg        = 1'b0;
        for (i = 0; i < 32; i++)
            pat_bytes[i] = 8'h00;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, empty pattern in exact mode
        push_item(8'h00, 1'b0, 1'b1);   // empty subject
        push_item(8'h41, 1'b0, 1'b0);   // idle item, dropped
        push_item(8'h00, 1'b1, 1'b1);   // one valid zero byte
        subjects_sent += 2;
        settle();

        // Contains with case folding
        pat_bytes[0] = 8'h61;
        pat_bytes[1] = 8'h5A;
        pat_len_cfg  = 2;
        mode_cfg     = sspm_pkg::MODE_CONTAINS;
        ic_cfg       = 1'b1;
        load_settings();
        push_item(8'h78, 1'b1, 1'b0);
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'h7A, 1'b1, 1'b0);
        push_item(8'h71, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b1);
        subjects_sent += 2;
        settle();

        // Suffix, case sensitive; second subject ends on an empty item
        mode_cfg = sspm_pkg::MODE_SUFFIX;
        ic_cfg   = 1'b0;
        load_settings();
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h5A, 1'b1, 1'b1);
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'h5A, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        subjects_sent += 2;
        settle();

        // Prefix with a tail, then an exact hit
        mode_cfg = sspm_pkg::MODE_PREFIX;
        load_settings();
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h5A, 1'b1, 1'b0);
        push_item(8'h01, 1'b1, 1'b1);
        settle();
        mode_cfg = sspm_pkg::MODE_EXACT;
        load_settings();
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h5A, 1'b1, 1'b1);
        subjects_sent += 2;
        settle();

        // Random phases; idling drops out over the last few
        for (ph = 0; ph < 17; ph++)
        begin
            choose_settings(ph);
            load_settings();
            idle_en  = (ph < 14);
            noise_en = (ph < 14);
            phase_start = items_sent;
            while (items_sent < phase_start + 95)
            begin
                build_subject();
                send_subject();
            end
            settle();

            // Back-pressure: hold the receiver off while short subjects keep
            // arriving, so the queue fills and the slave side stalls
            if (ph == 7)
            begin
                idle_en     = 1'b0;
                noise_en    = 1'b0;
                hold_cycles = 150;
                repeat (12)
                begin
                    subj.delete();
                    add_random($urandom_range(0, 4));
                    send_subject();
                end
                settle();
            end
        end

        $display("Covered %0d subjects (%0d item transfers) under %0d register settings.",
                 subjects_sent, items_sent, settings_used);
        $display("Checked %0d results, %0d of them matches; %0d mismatches.",
                 results_seen, matches_seen, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
src/sspm_pkg.sv
src/sspm_front.sv
src/sspm_queue.sv
src/sspm_back.sv
src/streaming_string_pattern_match.sv
tb/sv/sspm_match_check.sv
tb/sv/tb.sv
